// ----- hdl/sli_pkg.sv -----
// shared types and codes for the sorted insertion list core
// no dependencies; compiled first
package sli_pkg;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned OCC_W = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} sli_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} sli_status_t;

	// operation broadcast to every cell of the chain
	typedef struct packed {
		logic                    ins_en;
		logic                    del_en;
		logic signed [VAL_W-1:0] val;
	} sli_op_t;

endpackage

// ----- hdl/sli_req_if.sv -----
// request channel: command and operand with valid/ready
// depends on sli_pkg
interface sli_req_if
	import sli_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, cmd, value, input ready);
	modport sink (input valid, cmd, value, output ready);
endinterface

// ----- hdl/sli_rsp_if.sv -----
// response channel: status, occupancy and smallest value with valid/ready
// depends on sli_pkg
interface sli_rsp_if
	import sli_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [OCC_W-1:0]        occupancy;
	logic signed [VAL_W-1:0] smallest;
	logic                    smallest_valid;

	modport source (output valid, status, occupancy, smallest, smallest_valid, input ready);
	modport sink (input valid, status, occupancy, smallest, smallest_valid, output ready);
endinterface

// ----- hdl/sli_cell.sv -----
// one slot of the sorted chain: holds a value, compares it, shifts with neighbors
// depends on sli_pkg
module sli_cell
	import sli_pkg::*;
(
	input  logic                    clk,
	input  sli_op_t                 op,
	input  logic                    occupied,
	input  logic signed [VAL_W-1:0] prev_value,
	input  logic                    prev_lt,
	input  logic signed [VAL_W-1:0] next_value,
	output logic signed [VAL_W-1:0] value,
	output logic signed [VAL_W-1:0] value_nxt,
	output logic                    lt,
	output logic                    match
);

	logic signed [VAL_W-1:0] value_q;

	// local compare against the broadcast operand
	assign lt    = occupied && (value_q < op.val);
	assign match = occupied && (value_q == op.val);
	assign value = value_q;

	// insert shifts toward the tail, delete shifts toward the head
	always_comb begin
		value_nxt = value_q;
		if (op.ins_en && !lt) begin
			value_nxt = prev_lt ? op.val : prev_value;
		end else if (op.del_en && !lt) begin
			value_nxt = next_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

endmodule

// ----- hdl/sorted_list_insert_delete_core.sv -----
// sorted insertion list: chain of DEPTH compare-and-shift cells
// result is registered and presented in the cycle after the request transfer
// throughput: one operation per cycle while the response is taken; every cell compares and shifts in parallel
// reset: entry count and response valid clear; cell contents are not cleared
// depends on sli_pkg, sli_req_if, sli_rsp_if, sli_cell
module sorted_list_insert_delete_core
	import sli_pkg::*;
#(
	parameter int unsigned DEPTH = 16
)(
	input logic         clk,
	input logic         arst_n,
	sli_req_if.sink     req,
	sli_rsp_if.source   rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic signed [VAL_W-1:0] cell_val [DEPTH];
	logic signed [VAL_W-1:0] cell_nxt [DEPTH];
	logic [DEPTH-1:0]        occ;
	logic [DEPTH-1:0]        lt;
	logic [DEPTH-1:0]        match;

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_nxt;
	logic                    full;
	logic                    found;
	logic                    accept;
	sli_op_t                 op;
	sli_status_t             status_nxt;

	logic                    rsp_valid_q;
	logic [1:0]              rsp_status_q;
	logic [OCC_W-1:0]        rsp_occ_q;
	logic signed [VAL_W-1:0] rsp_small_q;
	logic                    rsp_small_valid_q;

	// handshake: output register frees when taken
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == CW'(DEPTH));
	assign found = |match;

	// operation decode
	always_comb begin
		op.val     = req.value;
		op.ins_en  = 1'b0;
		op.del_en  = 1'b0;
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		if (req.cmd == CMD_INSERT) begin
			if (full) begin
				status_nxt = ST_FULL;
			end else begin
				op.ins_en = accept;
				count_nxt = count_q + CW'(1);
			end
		end else begin
			if (found) begin
				op.del_en = accept;
				count_nxt = count_q - CW'(1);
			end else begin
				status_nxt = ST_NOT_FOUND;
			end
		end
	end

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] prev_v;
		logic signed [VAL_W-1:0] next_v;
		logic                    prev_l;

		assign occ[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_v = req.value;
			assign prev_l = 1'b1;
		end else begin : g_mid
			assign prev_v = cell_val[i-1];
			assign prev_l = lt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_v = cell_val[i];
		end else begin : g_body
			assign next_v = cell_val[i+1];
		end

		sli_cell u_cell (
			.clk        (clk),
			.op         (op),
			.occupied   (occ[i]),
			.prev_value (prev_v),
			.prev_lt    (prev_l),
			.next_value (next_v),
			.value      (cell_val[i]),
			.value_nxt  (cell_nxt[i]),
			.lt         (lt[i]),
			.match      (match[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (req.ready) begin
				rsp_valid_q <= req.valid;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_status_q      <= status_nxt;
			rsp_occ_q         <= OCC_W'(count_nxt);
			rsp_small_valid_q <= (count_nxt != '0);
			rsp_small_q       <= (count_nxt != '0) ? cell_nxt[0] : '0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.occupancy      = rsp_occ_q;
	assign rsp.smallest       = rsp_small_q;
	assign rsp.smallest_valid = rsp_small_valid_q;

	// ascending order check over occupied cells
	logic sorted_ok;
	always_comb begin
		sorted_ok = 1'b1;
		for (int k = 1; k < DEPTH; k++) begin
			if (occ[k] && (cell_val[k] < cell_val[k-1])) begin
				sorted_ok = 1'b0;
			end
		end
	end

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// occupied cells stay in ascending order
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_ok)
		else $error("cell chain out of order");

	// every transfer yields a result in the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("missing result after request transfer");

	// a refused insert leaves the count unchanged at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_INSERT && full) |=> (count_q == CW'(DEPTH)))
		else $error("count changed on refused insert");

endmodule
